### rtl/mmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants of the multiword modular fold
// Port field widths, configuration register indexes and the control word
// that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mmf_pkg;

  // Width of every word field on the ports
  localparam int unsigned WORD_W = 64;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_FIRST  = 1'b0,
    CFG_COEFF_SECOND = 1'b1
  } cfg_reg_e;

  // Shift code of a partial product: 0, one half or two halves
  localparam int unsigned SHF_W = 2;

  typedef struct packed {
    logic             issue;  // start one partial product
    logic             load;   // overwrite the accumulator
    logic [SHF_W-1:0] shf;    // half-word shift of the partial product
  } mac_ctrl_t;

endpackage

### rtl/mmf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_stream_if: valid/ready channels of the multiword modular fold
// One channel for the incoming words, one for the folded results.
// ----------------------------------------------------------------------------
interface mmf_in_if;
  logic                       valid;
  logic                       ready;
  logic [mmf_pkg::WORD_W-1:0] word_in;
  logic                       first_word;
  logic                       last_word;

  modport source (output valid, output word_in, output first_word, output last_word,
                  input ready);
  modport sink   (input valid, input word_in, input first_word, input last_word,
                  output ready);
endinterface

interface mmf_out_if;
  logic                       valid;
  logic                       ready;
  logic [mmf_pkg::WORD_W-1:0] rem_low;
  logic [mmf_pkg::WORD_W-1:0] rem_high;
  logic                       short_error;

  modport source (output valid, output rem_low, output rem_high, output short_error,
                  input ready);
  modport sink   (input valid, input rem_low, input rem_high, input short_error,
                  output ready);
endinterface

### rtl/mmf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_mac: shared half-word multiply-accumulate unit
// Multiplies two half-word operands into a product register, then adds the
// shifted product into a double-word accumulator on the next cycle.
// ----------------------------------------------------------------------------
module mmf_mac #(
  parameter int unsigned HALF_W = 32,
  parameter int unsigned SUM_W  = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmf_pkg::mac_ctrl_t  ctrl_i,
  input  logic [HALF_W-1:0]   a_i,
  input  logic [HALF_W-1:0]   b_i,
  input  logic [SUM_W-1:0]    load_val_i,
  output logic [SUM_W-1:0]    sum_o
);

  logic [2*HALF_W-1:0]       prod_q;
  logic [mmf_pkg::SHF_W-1:0] shf_q;
  logic                      pv_q;
  logic [SUM_W-1:0]          sum_q;
  logic [SUM_W-1:0]          prod_ext;
  logic [SUM_W-1:0]          addend;

  // Track which cycle holds a fresh product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.issue;
    end
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= a_i * b_i;
      shf_q  <= ctrl_i.shf;
    end
  end

  // Align the product to its half-word position
  assign prod_ext = SUM_W'(prod_q);

  always_comb begin
    case (shf_q)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext << HALF_W;
      default: addend = prod_ext << (2 * HALF_W);
    endcase
  end

  // Accumulate stage, wrapping at the double-word width
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sum_q <= load_val_i;
    end else if (pv_q) begin
      sum_q <= sum_q + addend;
    end
  end

  assign sum_o = sum_q;

endmodule

### rtl/multiword_mod_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiword_mod_fold: fold a long number into a two-word congruent value
// Words arrive most significant first; the block keeps a two-word running
// value and emits one result per number on its last word.
// ----------------------------------------------------------------------------
// Timing: the first two words of a number are loaded straight into the
// running value. Every later word is accepted and then passes through eight
// half-word partial products on the single shared multiplier, a drain state
// and an update state, and no new word is taken until it is done. After the
// last word the final fold adds four more partial products, a drain state and
// the output load. A number with fewer than three words yields short_error
// with a zero remainder in place of a result.
// Load coeff_first with 2^LIMB_BITS mod d and coeff_second with
// 2^(2*LIMB_BITS) mod d, only while the block is idle.
// ----------------------------------------------------------------------------
module multiword_mod_fold #(
  parameter int unsigned LIMB_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mmf_pkg::WORD_W-1:0]    cfg_data_i,
  mmf_in_if.sink                        in_i,
  mmf_out_if.source                     out_o
);

  localparam int unsigned HALF_W = (LIMB_BITS + 1) / 2;
  localparam int unsigned SUM_W  = 2 * LIMB_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FOLD   = 7'b0000010,
    S_FDRAIN = 7'b0000100,
    S_UPD    = 7'b0001000,
    S_FINAL  = 7'b0010000,
    S_XDRAIN = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e                     state_q, state_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic [1:0]                 phase_q, phase_d;
  logic                       last_q, last_d;
  logic                       short_q, short_d;
  logic [LIMB_BITS-1:0]       acc_high_q, acc_high_d;
  logic [LIMB_BITS-1:0]       acc_low_q, acc_low_d;
  logic [LIMB_BITS-1:0]       cf_q, cs_q;
  logic                       out_vld_q, out_vld_d;
  logic [mmf_pkg::WORD_W-1:0] rem_low_q, rem_high_q;
  logic                       short_err_q;

  logic                       accept;
  logic                       fold;
  logic                       out_load;
  logic [LIMB_BITS-1:0]       w;
  logic [LIMB_BITS-1:0]       opa, opb;
  logic [HALF_W-1:0]          a_half, b_half;
  logic [SUM_W-1:0]           load_val;
  logic [SUM_W-1:0]           sum;
  mmf_pkg::mac_ctrl_t         ctrl;

  // Handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign w          = in_i.word_in[LIMB_BITS-1:0];
  assign fold       = !in_i.first_word && (phase_q == 2'd2 || phase_q == 2'd3);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q <= '0;
      cs_q <= '0;
    end else if (cfg_we_i) begin
      case (mmf_pkg::cfg_reg_e'(cfg_idx_i))
        mmf_pkg::CFG_COEFF_FIRST:  cf_q <= cfg_data_i[LIMB_BITS-1:0];
        mmf_pkg::CFG_COEFF_SECOND: cs_q <= cfg_data_i[LIMB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pick the operands of the current partial product
  always_comb begin
    opa = '0;
    opb = '0;
    if (state_q == S_FOLD) begin
      if (cnt_q[2]) begin
        opa = acc_high_q;
        opb = cs_q;
      end else begin
        opa = acc_low_q;
        opb = cf_q;
      end
    end else if (state_q == S_FINAL) begin
      opa = acc_high_q;
      opb = cf_q;
    end
  end

  assign a_half = cnt_q[0] ? HALF_W'(opa >> HALF_W) : opa[HALF_W-1:0];
  assign b_half = cnt_q[1] ? HALF_W'(opb >> HALF_W) : opb[HALF_W-1:0];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    last_d     = last_q;
    short_d    = short_q;
    acc_high_d = acc_high_q;
    acc_low_d  = acc_low_q;
    ctrl       = '0;
    ctrl.shf   = mmf_pkg::SHF_W'(cnt_q[0]) + mmf_pkg::SHF_W'(cnt_q[1]);
    load_val   = '0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = in_i.last_word;
          short_d = 1'b0;
          if (fold) begin
            // seed the accumulator with the incoming word
            ctrl.load = 1'b1;
            load_val  = SUM_W'(w);
            phase_d   = 2'd3;
            cnt_d     = '0;
            state_d   = S_FOLD;
          end else begin
            if (in_i.first_word || phase_q == 2'd0) begin
              acc_high_d = w;
              acc_low_d  = '0;
              phase_d    = 2'd1;
            end else begin
              acc_low_d = w;
              phase_d   = 2'd2;
            end
            if (in_i.last_word) begin
              // number too short: drop it and flag the error
              short_d    = 1'b1;
              acc_high_d = '0;
              acc_low_d  = '0;
              phase_d    = 2'd0;
              state_d    = S_EMIT;
            end
          end
        end
      end
      S_FOLD: begin
        ctrl.issue = 1'b1;
        cnt_d      = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = S_FDRAIN;
        end
      end
      S_FDRAIN: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        acc_high_d = sum[SUM_W-1:LIMB_BITS];
        acc_low_d  = sum[LIMB_BITS-1:0];
        if (last_q) begin
          // final fold starts from the new low word
          ctrl.load = 1'b1;
          load_val  = SUM_W'(sum[LIMB_BITS-1:0]);
          cnt_d     = '0;
          state_d   = S_FINAL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FINAL: begin
        ctrl.issue = 1'b1;
        cnt_d      = cnt_q + 3'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = S_XDRAIN;
        end
      end
      S_XDRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load   = 1'b1;
          acc_high_d = '0;
          acc_low_d  = '0;
          phase_d    = 2'd0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      phase_q    <= '0;
      last_q     <= 1'b0;
      short_q    <= 1'b0;
      acc_high_q <= '0;
      acc_low_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      phase_q    <= phase_d;
      last_q     <= last_d;
      short_q    <= short_d;
      acc_high_q <= acc_high_d;
      acc_low_q  <= acc_low_d;
    end
  end

  // Shared multiply-accumulate unit
  mmf_mac #(
    .HALF_W (HALF_W),
    .SUM_W  (SUM_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .a_i        (a_half),
    .b_i        (b_half),
    .load_val_i (load_val),
    .sum_o      (sum)
  );

  // Output register: hold a beat until it is taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rem_low_q   <= short_q ? '0 : mmf_pkg::WORD_W'(sum[LIMB_BITS-1:0]);
      rem_high_q  <= short_q ? '0 : mmf_pkg::WORD_W'(sum[SUM_W-1:LIMB_BITS]);
      short_err_q <= short_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.rem_low     = rem_low_q;
  assign out_o.rem_high    = rem_high_q;
  assign out_o.short_error = short_err_q;

  // Checks
  a_emit_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_EMIT))
    else $error("result beat raised outside the emit state");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.short_error) |-> (out_o.rem_low == '0 && out_o.rem_high == '0))
    else $error("short number beat carries a nonzero remainder");

  a_final_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL || state_q == S_FOLD) |-> (phase_q == 2'd3))
    else $error("fold running with fewer than three words taken");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |-> (last_q && !short_q))
    else $error("final fold started without a last word");

endmodule
